[hdl/rrol_pkg.sv]
// Shared types and constants for the RGB range object locator.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package rrol_pkg;

    // Field widths
    localparam int COLOR_W  = 8;
    localparam int COORD_W  = 10;
    localparam int COUNT_W  = 21;
    localparam int EXTENT_W = COORD_W + 1;

    // Frame limits; pixels outside are never counted
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int LIMIT_W    = 13;

    // Match counter saturates here
    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(1048576);

    // Empty bounding box corners
    localparam logic [COORD_W-1:0] COORD_ALL_ONES = '1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PIXELS = 3'd6;

    // Reset values: yellow preset
    localparam logic [COLOR_W-1:0] RST_RED_LOW    = 8'd200;
    localparam logic [COLOR_W-1:0] RST_RED_HIGH   = 8'd255;
    localparam logic [COLOR_W-1:0] RST_GREEN_LOW  = 8'd180;
    localparam logic [COLOR_W-1:0] RST_GREEN_HIGH = 8'd255;
    localparam logic [COLOR_W-1:0] RST_BLUE_LOW   = 8'd0;
    localparam logic [COLOR_W-1:0] RST_BLUE_HIGH  = 8'd100;
    localparam logic [COUNT_W-1:0] RST_MIN_PIXELS = 21'd30;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Channel bounds seen by the classifier
    typedef struct packed {
        logic [COLOR_W-1:0] red_low;
        logic [COLOR_W-1:0] red_high;
        logic [COLOR_W-1:0] green_low;
        logic [COLOR_W-1:0] green_high;
        logic [COLOR_W-1:0] blue_low;
        logic [COLOR_W-1:0] blue_high;
    } t_bounds;

    // One classified pixel
    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_entry;

endpackage

[hdl/rrol_front.sv]
// Front end: classifies one pixel against the channel bounds.
// Depends on rrol_pkg.
`timescale 1ns / 1ps

module rrol_front (
    input  rrol_pkg::t_bounds                 i_bounds,
    input  logic [rrol_pkg::COLOR_W-1:0]      i_red,
    input  logic [rrol_pkg::COLOR_W-1:0]      i_green,
    input  logic [rrol_pkg::COLOR_W-1:0]      i_blue,
    input  logic [rrol_pkg::COORD_W-1:0]      i_pixel_row,
    input  logic [rrol_pkg::COORD_W-1:0]      i_pixel_col,
    input  logic                              i_frame_end,
    output rrol_pkg::t_entry                  o_entry
);
    import rrol_pkg::*;

    logic w_inside;
    logic w_red_ok;
    logic w_green_ok;
    logic w_blue_ok;

    // position must lie within the frame
    assign w_inside = ({{(LIMIT_W-COORD_W){1'b0}}, i_pixel_row} < LIMIT_W'(MAX_HEIGHT)) &&
                      ({{(LIMIT_W-COORD_W){1'b0}}, i_pixel_col} < LIMIT_W'(MAX_WIDTH));

    // inclusive range per channel; low above high never matches
    assign w_red_ok   = (i_red >= i_bounds.red_low) && (i_red <= i_bounds.red_high);
    assign w_green_ok = (i_green >= i_bounds.green_low) && (i_green <= i_bounds.green_high);
    assign w_blue_ok  = (i_blue >= i_bounds.blue_low) && (i_blue <= i_bounds.blue_high);

    always_comb begin
        o_entry.hit  = w_inside && w_red_ok && w_green_ok && w_blue_ok;
        o_entry.row  = i_pixel_row;
        o_entry.col  = i_pixel_col;
        o_entry.last = i_frame_end;
    end

endmodule

[hdl/rrol_queue.sv]
// Short FIFO of classified pixels between front and back.
// Depends on rrol_pkg.
`timescale 1ns / 1ps

module rrol_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rrol_pkg::t_entry  i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output rrol_pkg::t_entry  o_entry
);
    import rrol_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers wrap naturally at a power-of-two depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

[hdl/rrol_back.sv]
// Back end: frame accumulators, summary arithmetic and the output register.
// Depends on rrol_pkg.
`timescale 1ns / 1ps

module rrol_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rrol_pkg::COUNT_W-1:0]      i_min_pixels,
    input  logic                              i_empty,
    input  rrol_pkg::t_entry                  i_entry,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_in_range,
    output logic                              o_frame_done,
    output logic [rrol_pkg::COUNT_W-1:0]      o_match_total,
    output logic                              o_object_found,
    output logic [rrol_pkg::COORD_W-1:0]      o_center_col,
    output logic [rrol_pkg::COORD_W-1:0]      o_center_row,
    output logic signed [rrol_pkg::EXTENT_W-1:0] o_extent
);
    import rrol_pkg::*;

    // accumulators
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COORD_W-1:0] r_top, n_top;
    logic [COORD_W-1:0] r_bottom, n_bottom;
    logic [COORD_W-1:0] r_left, n_left;
    logic [COORD_W-1:0] r_right, n_right;

    // output register
    logic                r_out_valid;
    logic                r_in_range;
    logic                r_frame_done;
    logic [COUNT_W-1:0]  r_match_total;
    logic                r_object_found;
    logic [COORD_W-1:0]  r_center_col;
    logic [COORD_W-1:0]  r_center_row;
    logic [EXTENT_W-1:0] r_extent;

    logic                w_found;
    logic [COORD_W-1:0]  w_span_c;
    logic [COORD_W-1:0]  w_span_r;
    logic [COORD_W-1:0]  w_span_max;

    // take a pixel whenever the output register is free or being drained
    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);

    // accumulator update including the current pixel
    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        n_bottom = r_bottom;
        n_left   = r_left;
        n_right  = r_right;
        if (i_entry.hit) begin
            if (r_count < COUNT_SAT) begin
                n_count = r_count + 1'b1;
            end
            if (i_entry.row < r_top) begin
                n_top = i_entry.row;
            end
            if (i_entry.row > r_bottom) begin
                n_bottom = i_entry.row;
            end
            if (i_entry.col < r_left) begin
                n_left = i_entry.col;
            end
            if (i_entry.col > r_right) begin
                n_right = i_entry.col;
            end
        end
    end

    // summary; a found object always has a nonempty box
    assign w_found    = (n_count > i_min_pixels);
    assign w_span_c   = n_right - n_left;
    assign w_span_r   = n_bottom - n_top;
    assign w_span_max = (w_span_c > w_span_r) ? w_span_c : w_span_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_top    <= COORD_ALL_ONES;
            r_bottom <= '0;
            r_left   <= COORD_ALL_ONES;
            r_right  <= '0;
        end else if (o_pop) begin
            if (i_entry.last) begin
                r_count  <= '0;
                r_top    <= COORD_ALL_ONES;
                r_bottom <= '0;
                r_left   <= COORD_ALL_ONES;
                r_right  <= '0;
            end else begin
                r_count  <= n_count;
                r_top    <= n_top;
                r_bottom <= n_bottom;
                r_left   <= n_left;
                r_right  <= n_right;
            end
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload; summary fields are zero except on the frame end
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_in_range   <= i_entry.hit;
            r_frame_done <= i_entry.last;
            if (i_entry.last) begin
                r_match_total  <= n_count;
                r_object_found <= w_found;
                if (w_found) begin
                    r_center_col <= n_left + (w_span_c >> 1);
                    r_center_row <= n_top + (w_span_r >> 1);
                    r_extent     <= {1'b0, w_span_max};
                end else begin
                    r_center_col <= '0;
                    r_center_row <= '0;
                    r_extent     <= '1;
                end
            end else begin
                r_match_total  <= '0;
                r_object_found <= 1'b0;
                r_center_col   <= '0;
                r_center_row   <= '0;
                r_extent       <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_in_range     = r_in_range;
    assign o_frame_done   = r_frame_done;
    assign o_match_total  = r_match_total;
    assign o_object_found = r_object_found;
    assign o_center_col   = r_center_col;
    assign o_center_row   = r_center_row;
    assign o_extent       = $signed(r_extent);

endmodule

[hdl/rgb_range_object_locator_core.sv]
// RGB range object locator, top level: configuration registers and the
// front, queue and back instances. Depends on rrol_pkg and all rrol_* modules.
// An input request is written into the queue, then reaches the back end's
// output register. Throughput: one pixel per cycle while the output is not
// stalled, set by the accumulator update in the back end; a four-entry queue
// absorbs output stalls. Reset (synchronous, active low) loads the yellow
// preset bounds and a minimum of 30 pixels and clears the accumulators.
`timescale 1ns / 1ps

module rgb_range_object_locator_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rrol_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rrol_pkg::COUNT_W-1:0]          i_cfg_data,
    // pixel input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [rrol_pkg::COLOR_W-1:0]          i_red,
    input  logic [rrol_pkg::COLOR_W-1:0]          i_green,
    input  logic [rrol_pkg::COLOR_W-1:0]          i_blue,
    input  logic [rrol_pkg::COORD_W-1:0]          i_pixel_row,
    input  logic [rrol_pkg::COORD_W-1:0]          i_pixel_col,
    input  logic                                  i_frame_end,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_in_range,
    output logic                                  o_frame_done,
    output logic [rrol_pkg::COUNT_W-1:0]          o_match_total,
    output logic                                  o_object_found,
    output logic [rrol_pkg::COORD_W-1:0]          o_center_col,
    output logic [rrol_pkg::COORD_W-1:0]          o_center_row,
    output logic signed [rrol_pkg::EXTENT_W-1:0]  o_extent
);
    import rrol_pkg::*;

    t_bounds            r_bounds;
    logic [COUNT_W-1:0] r_min_pixels;

    t_entry w_front_entry;
    t_entry w_queue_entry;
    logic   w_full;
    logic   w_empty;
    logic   w_push;
    logic   w_pop;

    // configuration register file, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.red_low    <= RST_RED_LOW;
            r_bounds.red_high   <= RST_RED_HIGH;
            r_bounds.green_low  <= RST_GREEN_LOW;
            r_bounds.green_high <= RST_GREEN_HIGH;
            r_bounds.blue_low   <= RST_BLUE_LOW;
            r_bounds.blue_high  <= RST_BLUE_HIGH;
            r_min_pixels        <= RST_MIN_PIXELS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RED_LOW:    r_bounds.red_low    <= i_cfg_data[COLOR_W-1:0];
                CFG_RED_HIGH:   r_bounds.red_high   <= i_cfg_data[COLOR_W-1:0];
                CFG_GREEN_LOW:  r_bounds.green_low  <= i_cfg_data[COLOR_W-1:0];
                CFG_GREEN_HIGH: r_bounds.green_high <= i_cfg_data[COLOR_W-1:0];
                CFG_BLUE_LOW:   r_bounds.blue_low   <= i_cfg_data[COLOR_W-1:0];
                CFG_BLUE_HIGH:  r_bounds.blue_high  <= i_cfg_data[COLOR_W-1:0];
                CFG_MIN_PIXELS: r_min_pixels        <= i_cfg_data;
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    // input request accepted when the queue has room
    assign o_in_stall = w_full;
    assign w_push     = i_in_valid && !w_full;

    rrol_front u_front (
        .i_bounds    (r_bounds),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .i_frame_end (i_frame_end),
        .o_entry     (w_front_entry)
    );

    rrol_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_entry (w_queue_entry)
    );

    rrol_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_min_pixels   (r_min_pixels),
        .i_empty        (w_empty),
        .i_entry        (w_queue_entry),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_in_range     (o_in_range),
        .o_frame_done   (o_frame_done),
        .o_match_total  (o_match_total),
        .o_object_found (o_object_found),
        .o_center_col   (o_center_col),
        .o_center_row   (o_center_row),
        .o_extent       (o_extent)
    );

endmodule
